>>> rtl/los_pkg.sv
// Shared types and constants for the line-of-sight block.
package los_pkg;

    // Coordinate fields are fixed at six bits by the request format
    localparam int COORD_W    = 6;
    localparam int DEF_GRID_W = 64;
    localparam int DEF_GRID_H = 64;

    typedef logic [COORD_W-1:0] t_coord;

    // Request kinds
    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } t_req_kind;

    typedef struct packed {
        logic   req_type;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
        logic   wall_bit;
    } t_req;

    typedef struct packed {
        logic visible;
    } t_resp;

endpackage

>>> rtl/los_stream_if.sv
// Valid/ready stream interface used by the request and response channels.
interface los_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/line_of_sight_bresenham_top.sv
// Line-of-sight block: wall map memory and Bresenham walker.
//
//  channel  | dir | payload                                  | results
//  ---------+-----+------------------------------------------+------------------
//  i_req    | in  | req_type start_x start_y end_x end_y     | write: none
//           |     | wall_bit                                 | query: one
//  o_resp   | out | visible                                  | -
//
// After reset the map is cleared one cell per cycle, all GRID_W * GRID_H cells
// (4096 at the defaults), with i_req.ready low.
// A query checks each visited cell but the end cell, reading the map through
// the single read port, and resolves the last check before its result is stored.
// One item is in work at a time; the output register holds a finished result
// while the next request is taken. A query whose result cannot be stored waits
// in its final state until o_resp drains.
module line_of_sight_bresenham_top
    import los_pkg::*;
#(
    parameter int GRID_W = DEF_GRID_W,
    parameter int GRID_H = DEF_GRID_H
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    los_stream_if.sink           i_req,
    los_stream_if.source         o_resp
);

    localparam int MEM_DEPTH = GRID_W * GRID_H;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int DW        = COORD_W + 1;   // deltas
    localparam int ERR_W     = COORD_W + 4;   // signed error term

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WALK  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Wall map and its registered read data
    logic        r_mem [MEM_DEPTH];
    logic        r_rd_data;
    logic        r_chk_v;
    logic        r_chk_out;

    logic [AW-1:0] r_clr_addr;

    // Walk state
    t_coord                   r_x, r_y, r_ex, r_ey;
    logic       [DW-1:0]      r_dx, r_dy;
    logic                     r_sx_pos, r_sy_pos;
    logic signed [ERR_W-1:0]  r_err;
    logic                     r_blocked;

    // Output register
    logic r_out_valid;
    logic r_out_vis;

    logic req_xfer, resp_xfer;
    logic wr_en, wr_data, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic cur_outside, wr_outside, at_end, hit, final_blocked;
    logic signed [ERR_W:0] twice;
    logic step_x, step_y;
    logic [DW-1:0] q_dx, q_dy;

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_resp.valid      = r_out_valid;
    assign o_resp.data.visible = r_out_vis;

    assign req_xfer  = i_req.valid && i_req.ready;
    assign resp_xfer = r_out_valid && o_resp.ready;

    // Grid bounds checks
    assign cur_outside = (32'(r_x) >= 32'(GRID_W)) || (32'(r_y) >= 32'(GRID_H));
    assign wr_outside  = (32'(i_req.data.start_x) >= 32'(GRID_W)) ||
                         (32'(i_req.data.start_y) >= 32'(GRID_H));

    // Map write port: clearing pass or a write transfer
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_data = 1'b0;
        if (r_state == S_CLEAR) begin
            wr_en = 1'b1;
        end else if (req_xfer && i_req.data.req_type == REQ_WRITE && !wr_outside) begin
            wr_en   = 1'b1;
            wr_addr = AW'(32'(i_req.data.start_y) * GRID_W + 32'(i_req.data.start_x));
            wr_data = i_req.data.wall_bit;
        end
    end

    // Map read port: one on-grid visited cell per walk cycle, the end cell apart
    assign at_end  = (r_x == r_ex) && (r_y == r_ey);
    assign rd_en   = (r_state == S_WALK) && !at_end && !cur_outside;
    assign rd_addr = AW'(32'(r_y) * GRID_W + 32'(r_x));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // A wall or an off-grid cell read in the previous cycle blocks the line
    assign hit           = r_chk_v && (r_rd_data || r_chk_out);
    assign final_blocked = r_blocked || hit;

    // Bresenham step decisions
    assign twice  = {r_err, 1'b0};
    assign step_x = twice > -$signed({1'b0, r_dy});
    assign step_y = twice < $signed({1'b0, r_dx});

    assign q_dx = (i_req.data.end_x > i_req.data.start_x)
                ? DW'(i_req.data.end_x - i_req.data.start_x)
                : DW'(i_req.data.start_x - i_req.data.end_x);
    assign q_dy = (i_req.data.end_y > i_req.data.start_y)
                ? DW'(i_req.data.end_y - i_req.data.start_y)
                : DW'(i_req.data.start_y - i_req.data.end_y);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (32'(r_clr_addr) == MEM_DEPTH - 1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (req_xfer && i_req.data.req_type == REQ_QUERY) n_state = S_WALK;
            end
            S_WALK: begin
                if (at_end) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_resp.ready) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk_v <= (r_state == S_WALK) && !at_end;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_DONE && (!r_out_valid || o_resp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (resp_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk datapath and result payload
    always_ff @(posedge i_clk) begin
        r_chk_out <= cur_outside;
        if (req_xfer) begin
            r_x       <= i_req.data.start_x;
            r_y       <= i_req.data.start_y;
            r_ex      <= i_req.data.end_x;
            r_ey      <= i_req.data.end_y;
            r_dx      <= q_dx;
            r_dy      <= q_dy;
            r_sx_pos  <= i_req.data.start_x < i_req.data.end_x;
            r_sy_pos  <= i_req.data.start_y < i_req.data.end_y;
            r_err     <= ERR_W'($signed({1'b0, q_dx})) - ERR_W'($signed({1'b0, q_dy}));
            r_blocked <= 1'b0;
        end else begin
            r_blocked <= final_blocked;
            if (r_state == S_WALK && !at_end) begin
                r_err <= r_err - (step_x ? ERR_W'($signed({1'b0, r_dy})) : '0)
                               + (step_y ? ERR_W'($signed({1'b0, r_dx})) : '0);
                if (step_x) r_x <= r_sx_pos ? r_x + 1'b1 : r_x - 1'b1;
                if (step_y) r_y <= r_sy_pos ? r_y + 1'b1 : r_y - 1'b1;
            end
        end
        if (r_state == S_DONE && (!r_out_valid || o_resp.ready)) begin
            r_out_vis <= !final_blocked;
        end
    end

endmodule

>>> rtl/los_checker.sv
// Port-level checks for the line-of-sight block, bound to the top level.
module los_checker
    import los_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_req_valid,
    input logic  i_req_ready,
    input t_req  i_req_data,
    input logic  i_resp_valid,
    input logic  i_resp_ready,
    input t_resp i_resp_data
);

    logic req_xfer;
    assign req_xfer = i_req_valid && i_req_ready;

    // A stalled result holds its value
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_resp_valid && !i_resp_ready |=> i_resp_valid && $stable(i_resp_data))
        else $error("result changed while stalled");

    // The map clear runs right after reset, so no request is taken then
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("request taken during map clear");

    // A write never produces a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer && i_req_data.req_type == REQ_WRITE && !i_resp_valid |=> !i_resp_valid)
        else $error("result after a write");

    // A query blocks the request side while it walks
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer && i_req_data.req_type == REQ_QUERY |=> !i_req_ready)
        else $error("request taken during a query");

    // A query whose start equals its end gives a visible result
    a_same_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer && i_req_data.req_type == REQ_QUERY && !i_resp_valid &&
        i_req_data.start_x == i_req_data.end_x &&
        i_req_data.start_y == i_req_data.end_y
        |-> ##3 i_resp_valid && i_resp_data.visible)
        else $error("same-cell query not visible");

endmodule

bind line_of_sight_bresenham_top los_checker u_los_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_data   (i_req.data),
    .i_resp_valid (o_resp.valid),
    .i_resp_ready (o_resp.ready),
    .i_resp_data  (o_resp.data)
);
